>>> rtl/i2c_master_transaction_engine_macros.svh
// Assertion macros shared by the checker of the I2C master transaction engine.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2C_MTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2C_MTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/i2c_mte_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the I2C master transaction engine.
// No dependencies.
package i2c_mte_pkg;

    localparam logic [4:0]  MAX_READ_BYTES = 5'd16;
    localparam logic [15:0] HALF_RESET     = 16'd5;
    localparam logic [1:0]  ST_OK          = 2'd0;
    localparam logic [1:0]  ST_ADDR_NACK   = 2'd1;
    localparam logic [1:0]  ST_DATA_NACK   = 2'd2;
    localparam logic [7:0]  BIT_MSB        = 8'h80;
    localparam logic [3:0]  BITS_PER_BYTE  = 4'd8;

    // APB register indexes
    localparam logic REG_HALF_PERIOD = 1'b0;

    typedef struct packed {
        logic       cmd_valid;
        logic       mode;
        logic [7:0] device_address;
        logic [7:0] write_data;
        logic [4:0] read_count;
        logic       sda_sample;
    } cmd_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_pull_low;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       read_last;
        logic       done_res;
        logic [1:0] status;
    } res_t;

endpackage

>>> rtl/i2c_mte_cfg.sv
`timescale 1ns / 1ps
// APB register file: holds the SCL half period in ticks.
// Depends on i2c_mte_pkg.
module i2c_mte_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] half_period
);
    import i2c_mte_pkg::*;

    logic [15:0] half_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_HALF_PERIOD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_RESET;
        end
        else if (wr_en)
        begin
            half_reg <= pwdata[15:0];
        end
    end

    assign prdata      = (paddr[2] == REG_HALF_PERIOD) ? {16'd0, half_reg} : 32'd0;
    assign half_period = half_reg;

endmodule

>>> rtl/i2c_mte_core.sv
`timescale 1ns / 1ps
// Bus sequencer: consumes one tick per fire, updates state, gives that tick's result.
// Depends on i2c_mte_pkg.
module i2c_mte_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  i2c_mte_pkg::cmd_t   cmd,
    input  logic [15:0]         half_period,
    output i2c_mte_pkg::res_t   res
);
    import i2c_mte_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START1, PH_START2, PH_TX_LOW, PH_TX_HIGH, PH_ACK_LOW, PH_ACK_HIGH,
        PH_RX_LOW, PH_RX_HIGH, PH_MACK_LOW, PH_MACK_HIGH, PH_STOP1, PH_STOP2, PH_STOP3
    } phase_t;

    phase_t      phase_reg, phase_next, ph;
    logic [15:0] tick_reg, tick_next, tc, tc_inc, h_eff;
    logic [3:0]  bit_reg, bit_next, bi, bi_inc;
    logic [7:0]  shift_reg, shift_next, sb;
    logic [4:0]  left_reg, left_next, bl, cnt;
    logic [7:0]  data_reg, data_next, hd;
    logic        mode_reg, mode_next, hm;
    logic        stage_reg, stage_next, hs;

    assign h_eff = (half_period == 16'd0) ? 16'd1 : half_period;

    always_comb
    begin
        if (cmd.read_count == 5'd0)
            cnt = 5'd1;
        else if (cmd.read_count > MAX_READ_BYTES)
            cnt = MAX_READ_BYTES;
        else
            cnt = cmd.read_count;
    end

    always_comb
    begin
        ph = phase_reg;
        tc = tick_reg;
        bi = bit_reg;
        sb = shift_reg;
        bl = left_reg;
        hd = data_reg;
        hm = mode_reg;
        hs = stage_reg;
        res = '0;
        res.scl_level = 1'b1;

        // command taken only when idle
        if (phase_reg == PH_IDLE && cmd.cmd_valid)
        begin
            hd = cmd.write_data;
            hm = cmd.mode;
            hs = 1'b0;
            sb = cmd.mode ? (cmd.device_address + 8'd1) : cmd.device_address;
            bl = cnt;
            bi = 4'd0;
            tc = 16'd0;
            ph = PH_START1;
        end

        tc_inc     = tc + 16'd1;
        bi_inc     = bi + 4'd1;
        phase_next = ph;
        tick_next  = tc;
        bit_next   = bi;
        shift_next = sb;
        left_next  = bl;
        data_next  = hd;
        mode_next  = hm;
        stage_next = hs;

        if (ph != PH_IDLE)
        begin
            res.busy_res = 1'b1;
            case (ph)
                PH_START1:    begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
                PH_START2:    begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
                PH_TX_LOW:    begin res.scl_level = 1'b0; res.sda_pull_low = ~sb[7]; end
                PH_TX_HIGH:   begin res.scl_level = 1'b1; res.sda_pull_low = ~sb[7]; end
                PH_ACK_LOW,
                PH_RX_LOW:    begin res.scl_level = 1'b0; res.sda_pull_low = 1'b0; end
                PH_ACK_HIGH,
                PH_RX_HIGH:   begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
                PH_MACK_LOW:  begin res.scl_level = 1'b0; res.sda_pull_low = (bl > 5'd1); end
                PH_MACK_HIGH: begin res.scl_level = 1'b1; res.sda_pull_low = (bl > 5'd1); end
                PH_STOP1:     begin res.scl_level = 1'b0; res.sda_pull_low = 1'b1; end
                PH_STOP2:     begin res.scl_level = 1'b1; res.sda_pull_low = 1'b1; end
                default:      begin res.scl_level = 1'b1; res.sda_pull_low = 1'b0; end
            endcase

            tick_next = tc_inc;
            if (tc_inc >= h_eff)
            begin
                tick_next = 16'd0;
                case (ph)
                    PH_START1:   phase_next = PH_START2;
                    PH_START2:   phase_next = PH_TX_LOW;
                    PH_TX_LOW:   phase_next = PH_TX_HIGH;
                    PH_TX_HIGH:
                    begin
                        shift_next = {sb[6:0], 1'b0};
                        bit_next   = bi_inc;
                        phase_next = (bi_inc >= BITS_PER_BYTE) ? PH_ACK_LOW : PH_TX_LOW;
                    end
                    PH_ACK_LOW:  phase_next = PH_ACK_HIGH;
                    PH_ACK_HIGH:
                    begin
                        if (cmd.sda_sample)
                        begin
                            // slave NACK: abort through STOP
                            bit_next   = {2'b00, hs ? ST_DATA_NACK : ST_ADDR_NACK};
                            phase_next = PH_STOP1;
                        end
                        else if (hm)
                        begin
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RX_LOW;
                        end
                        else if (!hs)
                        begin
                            stage_next = 1'b1;
                            shift_next = hd;
                            bit_next   = 4'd0;
                            phase_next = PH_TX_LOW;
                        end
                        else
                        begin
                            bit_next   = {2'b00, ST_OK};
                            phase_next = PH_STOP1;
                        end
                    end
                    PH_RX_LOW:   phase_next = PH_RX_HIGH;
                    PH_RX_HIGH:
                    begin
                        shift_next = {sb[6:0], cmd.sda_sample};
                        bit_next   = bi_inc;
                        if (bi_inc >= BITS_PER_BYTE)
                        begin
                            res.read_valid = 1'b1;
                            res.read_byte  = {sb[6:0], cmd.sda_sample};
                            res.read_last  = (bl <= 5'd1);
                            phase_next     = PH_MACK_LOW;
                        end
                        else
                        begin
                            phase_next = PH_RX_LOW;
                        end
                    end
                    PH_MACK_LOW: phase_next = PH_MACK_HIGH;
                    PH_MACK_HIGH:
                    begin
                        if (bl > 5'd1)
                        begin
                            left_next  = bl - 5'd1;
                            bit_next   = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RX_LOW;
                        end
                        else
                        begin
                            left_next  = 5'd0;
                            bit_next   = {2'b00, ST_OK};
                            phase_next = PH_STOP1;
                        end
                    end
                    PH_STOP1:    phase_next = PH_STOP2;
                    PH_STOP2:    phase_next = PH_STOP3;
                    default:
                    begin
                        // end of STOP: status was parked in the bit counter
                        res.done_res = 1'b1;
                        res.status   = bi[1:0];
                        bit_next     = 4'd0;
                        data_next    = 8'd0;
                        mode_next    = 1'b0;
                        stage_next   = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 16'd0;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            left_reg  <= 5'd0;
            data_reg  <= 8'd0;
            mode_reg  <= 1'b0;
            stage_reg <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            left_reg  <= left_next;
            data_reg  <= data_next;
            mode_reg  <= mode_next;
            stage_reg <= stage_next;
        end
    end

endmodule

>>> rtl/i2c_master_transaction_engine.sv
`timescale 1ns / 1ps
// Top level of the I2C master transaction engine: stream ports, APB port, pipeline regs.
// Depends on i2c_mte_pkg, i2c_mte_cfg and i2c_mte_core.
//
//  channel   | direction | beat carries
//  ----------+-----------+-------------------------------------------------
//  s_*       | in        | one timer tick: sampled SDA and optional command
//  m_*       | out       | one result per tick: pin levels, busy, read byte, done
//  APB       | in/out    | register 0: half_period_ticks (16 bit, reset 5)
//
// One tick beat per clock cycle sustained while m_* is not stalled; a beat is held in the
// input register, then its result is loaded into the result register when the sequencer
// advances, so m_tvalid rises at the edge that loads the result register.
// The sequencer state advances only when the input register holds a beat and
// the result register is free or being drained, so back-pressure on m_* stalls s_*.
// Reset is asynchronous active low; it clears the sequencer to idle and both
// pipeline valid flags. No clearing pass: the block is ready right after reset.
module i2c_master_transaction_engine (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // device_address[7:0], write_data[15:8],
                                   // read_count[20:16], sda_sample[21], zero pad
    input  logic [1:0]  s_tuser,   // cmd_valid[0], mode[1]
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // scl_level[0], sda_pull_low[1], busy_res[2],
                                   // read_valid[3], read_byte[11:4], done_res[12],
                                   // status[14:13], zero pad
    output logic        m_tlast,   // read_last
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2c_mte_pkg::*;

    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    logic        out_valid_reg;
    res_t        out_res_reg;
    res_t        core_res;
    logic        advance;
    logic        s_beat;
    logic [15:0] half_period;

    i2c_mte_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .half_period (half_period)
    );

    // a tick moves through the sequencer when the result slot is free or draining
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign s_beat   = s_tvalid & s_tready;

    i2c_mte_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (advance),
        .cmd         (in_cmd_reg),
        .half_period (half_period),
        .res         (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_beat)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_beat)
        begin
            in_cmd_reg.cmd_valid      <= s_tuser[0];
            in_cmd_reg.mode           <= s_tuser[1];
            in_cmd_reg.device_address <= s_tdata[7:0];
            in_cmd_reg.write_data     <= s_tdata[15:8];
            in_cmd_reg.read_count     <= s_tdata[20:16];
            in_cmd_reg.sda_sample     <= s_tdata[21];
        end
        if (advance)
            out_res_reg <= core_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg.status, out_res_reg.done_res, out_res_reg.read_byte,
                       out_res_reg.read_valid, out_res_reg.busy_res,
                       out_res_reg.sda_pull_low, out_res_reg.scl_level};
    assign m_tlast  = out_res_reg.read_last;

endmodule

>>> rtl/i2c_mte_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the I2C master transaction engine, bound to the top level.
// Depends on i2c_master_transaction_engine_macros.svh.
`include "i2c_master_transaction_engine_macros.svh"

module i2c_mte_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tlast
);

    `I2C_MTE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")
    `I2C_MTE_ASSERT_NOW(a_last_has_byte, m_tvalid && m_tlast, m_tdata[3], "tlast without read byte")
    `I2C_MTE_ASSERT_NOW(a_status_on_done, m_tvalid && (m_tdata[13] || m_tdata[14]), m_tdata[12] && !(m_tdata[13] && m_tdata[14]), "status outside done or invalid")
    `I2C_MTE_ASSERT_NOW(a_rx_scl_high, m_tvalid && m_tdata[3], m_tdata[2] && m_tdata[0] && !m_tdata[1], "read byte outside SCL high half")
    `I2C_MTE_ASSERT_NOW(a_idle_bus, m_tvalid && !m_tdata[2], m_tdata[0] && !m_tdata[1] && !m_tdata[3] && !m_tdata[12], "idle beat drives bus")

endmodule

bind i2c_master_transaction_engine i2c_mte_checker u_i2c_mte_checker (.*);
